>>> hdl/mrks_pkg.sv
package mrks_pkg;

	localparam int unsigned STORE_LEN = 11;
	localparam int unsigned FIRST_POS = 3;
	localparam int unsigned COUNT_MAX = 14;

	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef logic [1:0] ring_stage_t;
	typedef logic [2:0] clip_stage_t;
	typedef logic [3:0] cap_count_t;
	typedef logic [6:0] num_char_t;

endpackage

>>> hdl/modem_response_keyword_scanner_top.sv
// Modem response keyword scanner.
//
// Input channel: byte_valid / byte_ready carry one received modem byte
// (rx_byte) per word. Bytes of 0 or of 128 and above change no state but
// still produce a result word with every field 0.
// Output channel: result_valid / result_ready carry one result word per
// input word: RING, +CLIP: and OK event pulses, and on the line feed that
// ends a caller number capture, number_ready with the eleven captured
// characters split over number_head and number_tail (zero otherwise).
// An accepted byte is held in the input register and its result is loaded
// into the result register once that register is free; result_valid then
// stays high until the word is taken.
// Throughput: one byte per cycle while result words are taken, set by the
// single pass of compare logic between the input register and the result
// register; the matcher state updates in the same edge that loads the result.
// Reset (arst_n low): clears matchers, capture state, the caller number
// store and both valid flags at once; no clearing pass is needed.
// When the receiver stalls, the result word holds, the input register fills,
// and byte_ready drops until the result word is taken.
module modem_response_keyword_scanner_top
	import mrks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        ring_event,
	output logic        clip_event,
	output logic        ok_event,
	output logic        number_ready,
	output logic [41:0] number_head,
	output logic [34:0] number_tail
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic        res_valid_q;
	logic        ring_ev_q, clip_ev_q, ok_ev_q, ready_q;
	logic [41:0] head_q;
	logic [34:0] tail_q;

	// scanner state
	ring_stage_t ring_stage_q;
	clip_stage_t clip_stage_q;
	logic        ok_stage_q;
	logic        cap_active_q;
	cap_count_t  cap_count_q;
	num_char_t   store_q [STORE_LEN];

	logic res_free, advance;

	// next-state and result logic
	logic        byte_ok;
	ring_stage_t ring_stage_d;
	clip_stage_t clip_stage_d;
	logic        ok_stage_d;
	logic        cap_active_d;
	cap_count_t  cap_count_d;
	logic        ring_ev_d, clip_ev_d, ok_ev_d, ready_d;
	logic        cap_mid, skip_ok, store_we;
	cap_count_t  store_idx;
	logic [41:0] head_d;
	logic [34:0] tail_d;

	assign res_free   = !res_valid_q || result_ready;
	assign advance    = valid_s1 && res_free;
	assign byte_ready = !valid_s1 || res_free;

	assign store_idx = cap_count_q - cap_count_t'(FIRST_POS);

	always_comb begin
		byte_ok      = (byte_s1 != 8'h00) && !byte_s1[7];
		ring_stage_d = ring_stage_q;
		clip_stage_d = clip_stage_q;
		ok_stage_d   = ok_stage_q;
		cap_active_d = cap_active_q;
		cap_count_d  = cap_count_q;
		ring_ev_d    = 1'b0;
		clip_ev_d    = 1'b0;
		ok_ev_d      = 1'b0;
		ready_d      = 1'b0;
		skip_ok      = 1'b0;
		store_we     = 1'b0;
		cap_mid      = cap_active_q;
		head_d       = '0;
		tail_d       = '0;

		if (byte_ok) begin
			// RING
			if (byte_s1 == CH_R) ring_stage_d = 2'd1;
			else if (byte_s1 == CH_I && ring_stage_q == 2'd1) ring_stage_d = 2'd2;
			else if (byte_s1 == CH_N && ring_stage_q == 2'd2) ring_stage_d = 2'd3;
			else if (byte_s1 == CH_G && ring_stage_q == 2'd3) begin
				ring_stage_d = 2'd0;
				ring_ev_d    = 1'b1;
			end else ring_stage_d = 2'd0;

			// +CLIP:
			if (byte_s1 == CH_PLUS) clip_stage_d = 3'd1;
			else if (byte_s1 == CH_C && clip_stage_q == 3'd1) clip_stage_d = 3'd2;
			else if (byte_s1 == CH_L && clip_stage_q == 3'd2) clip_stage_d = 3'd3;
			else if (byte_s1 == CH_I && clip_stage_q == 3'd3) clip_stage_d = 3'd4;
			else if (byte_s1 == CH_P && clip_stage_q == 3'd4) clip_stage_d = 3'd5;
			else if (byte_s1 == CH_COLON && clip_stage_q == 3'd5) begin
				clip_stage_d = 3'd0;
				clip_ev_d    = 1'b1;
				cap_mid      = 1'b1;
			end else clip_stage_d = 3'd0;

			cap_active_d = cap_mid;

			// capture: the completing colon counts as position 0
			if (cap_mid) begin
				if (byte_s1 == CH_CR) begin
					skip_ok = 1'b1;
				end else if (byte_s1 == CH_LF) begin
					skip_ok      = 1'b1;
					cap_count_d  = '0;
					cap_active_d = 1'b0;
					ready_d      = 1'b1;
					head_d = {store_q[0], store_q[1], store_q[2],
						store_q[3], store_q[4], store_q[5]};
					tail_d = {store_q[6], store_q[7], store_q[8],
						store_q[9], store_q[10]};
				end else if (cap_count_q < cap_count_t'(COUNT_MAX)) begin
					store_we    = (cap_count_q >= cap_count_t'(FIRST_POS));
					cap_count_d = cap_count_q + 4'd1;
				end
			end

			// OK, bypassed by CR and LF inside a capture
			if (!skip_ok) begin
				if (byte_s1 == CH_O) ok_stage_d = 1'b1;
				else if (byte_s1 == CH_K && ok_stage_q) begin
					ok_stage_d = 1'b0;
					ok_ev_d    = 1'b1;
				end else ok_stage_d = 1'b0;
			end
		end
	end

	// input register: load whenever there is room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) byte_s1 <= rx_byte;
	end

	// result register and scanner state advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			ring_stage_q <= '0;
			clip_stage_q <= '0;
			ok_stage_q   <= 1'b0;
			cap_active_q <= 1'b0;
			cap_count_q  <= '0;
			for (int i = 0; i < STORE_LEN; i++) store_q[i] <= '0;
		end else begin
			if (res_free) res_valid_q <= valid_s1;
			if (advance) begin
				ring_stage_q <= ring_stage_d;
				clip_stage_q <= clip_stage_d;
				ok_stage_q   <= ok_stage_d;
				cap_active_q <= cap_active_d;
				cap_count_q  <= cap_count_d;
				if (store_we) store_q[store_idx] <= byte_s1[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ring_ev_q <= ring_ev_d;
			clip_ev_q <= clip_ev_d;
			ok_ev_q   <= ok_ev_d;
			ready_q   <= ready_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
		end
	end

	assign result_valid = res_valid_q;
	assign ring_event   = ring_ev_q;
	assign clip_event   = clip_ev_q;
	assign ok_event     = ok_ev_q;
	assign number_ready = ready_q;
	assign number_head  = head_q;
	assign number_tail  = tail_q;

	// the four events are completed by distinct bytes
	a_events_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({ring_event, clip_event, ok_event, number_ready}))
		else $error("more than one event in a result word");

	// number fields are zero unless a capture has just ended
	a_num_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !number_ready) |-> (number_head == '0 && number_tail == '0))
		else $error("number fields set without number_ready");

	// the position count stays within its saturation limit
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cap_count_q <= cap_count_t'(COUNT_MAX))
		else $error("capture count beyond its limit");

	// a position count only exists inside a capture
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cap_active_q |-> (cap_count_q == '0))
		else $error("capture count left over outside a capture");

	// a reported number closes the capture
	a_ready_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ready_d) |=> !cap_active_q)
		else $error("capture still active after number_ready");

endmodule

>>> verif/mrks_result_checker.sv
module mrks_result_checker
	import mrks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  rx_byte,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        ring_event,
	input  logic        clip_event,
	input  logic        ok_event,
	input  logic        number_ready,
	input  logic [41:0] number_head,
	input  logic [34:0] number_tail,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        ring;
		logic        clip;
		logic        ok;
		logic        ready;
		logic [41:0] head;
		logic [34:0] tail;
	} scan_word_t;

	// Own copy of the matcher and capture state
	ring_stage_t ring_at;
	clip_stage_t clip_at;
	logic        ok_at;
	logic        capturing;
	cap_count_t  cap_pos;
	num_char_t   caller[STORE_LEN];

	scan_word_t expected_words[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic scan_word_t scan_byte(input logic [7:0] b);
		scan_word_t w;
		logic skip_ok;
		int i;
		w = '0;
		skip_ok = 1'b0;
		if (b == 8'h00 || b[7])
			return w;

		if (b == CH_R) ring_at = 2'd1;
		else if (b == CH_I && ring_at == 2'd1) ring_at = 2'd2;
		else if (b == CH_N && ring_at == 2'd2) ring_at = 2'd3;
		else if (b == CH_G && ring_at == 2'd3) begin
			ring_at = 2'd0;
			w.ring = 1'b1;
		end else ring_at = 2'd0;

		if (b == CH_PLUS) clip_at = 3'd1;
		else if (b == CH_C && clip_at == 3'd1) clip_at = 3'd2;
		else if (b == CH_L && clip_at == 3'd2) clip_at = 3'd3;
		else if (b == CH_I && clip_at == 3'd3) clip_at = 3'd4;
		else if (b == CH_P && clip_at == 3'd4) clip_at = 3'd5;
		else if (b == CH_COLON && clip_at == 3'd5) begin
			clip_at = 3'd0;
			w.clip = 1'b1;
			capturing = 1'b1;
		end else clip_at = 3'd0;

		if (capturing) begin
			if (b == CH_CR) begin
				skip_ok = 1'b1;
			end else if (b == CH_LF) begin
				skip_ok = 1'b1;
				cap_pos = '0;
				capturing = 1'b0;
				w.ready = 1'b1;
				for (i = 0; i < 6; i++)
					w.head = {w.head[34:0], caller[i]};
				for (i = 6; i < STORE_LEN; i++)
					w.tail = {w.tail[27:0], caller[i]};
			end else if (cap_pos < COUNT_MAX) begin
				if (cap_pos >= FIRST_POS)
					caller[cap_pos - FIRST_POS] = b[6:0];
				cap_pos = cap_pos + 1'b1;
			end
		end

		if (!skip_ok) begin
			if (b == CH_O) ok_at = 1'b1;
			else if (b == CH_K && ok_at) begin
				ok_at = 1'b0;
				w.ok = 1'b1;
			end else ok_at = 1'b0;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [41:0] got,
			input logic [41:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_word_t want;
		if (!arst_n) begin
			ring_at = '0;
			clip_at = '0;
			ok_at = 1'b0;
			capturing = 1'b0;
			cap_pos = '0;
			for (int i = 0; i < STORE_LEN; i++)
				caller[i] = '0;
			expected_words.delete();
			pending = 0;
		end else begin
			// Take the result first: a byte accepted at this edge cannot have its word out yet
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					check_field("ring_event", ring_event, want.ring);
					check_field("clip_event", clip_event, want.clip);
					check_field("ok_event", ok_event, want.ok);
					check_field("number_ready", number_ready, want.ready);
					check_field("number_head", number_head, want.head);
					check_field("number_tail", number_tail, want.tail);
				end
			end
			if (byte_valid && byte_ready)
				expected_words.push_back(scan_byte(rx_byte));
			pending = expected_words.size();
		end
	end

endmodule

>>> verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mrks_pkg::*;

	// Receiver stall patterns, switched at random intervals
	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_BURSTY
	} ready_mode_t;

	// Shapes of random traffic
	typedef enum int {
		SEQ_CLIP,
		SEQ_RING,
		SEQ_OK,
		SEQ_BROKEN,
		SEQ_NOISE
	} seq_kind_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_ready;
	logic        ring_event;
	logic        clip_event;
	logic        ok_event;
	logic        number_ready;
	logic [41:0] number_head;
	logic [34:0] number_tail;

	int mismatches;
	int pending;

	int          burst_left = 0;
	int          bytes_sent = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int          mode_left = 0;

	modem_response_keyword_scanner_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.ring_event   (ring_event),
		.clip_event   (clip_event),
		.ok_event     (ok_event),
		.number_ready (number_ready),
		.number_head  (number_head),
		.number_tail  (number_tail)
	);

	mrks_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.ring_event   (ring_event),
		.clip_event   (clip_event),
		.ok_event     (ok_event),
		.number_ready (number_ready),
		.number_head  (number_head),
		.number_tail  (number_tail),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: hold each stall pattern for a random stretch, then pick another.
	// The always-ready pattern gives stretches where the output never backs up.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: result_ready <= 1'b1;
			READY_COIN:   result_ready <= 1'($urandom_range(0, 1));
			READY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
			default:      result_ready <= ((mode_left % 16) < 4);
		endcase
	end

	// Offer one word and hold it until the block takes it. At the end of a burst,
	// drop valid for a random gap; otherwise keep valid high for the next word.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		byte_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			byte_valid <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			// Mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Stop sending and wait until every expected word has come back.
	// Sample on the falling edge so the checker's count is settled.
	task automatic drain;
		byte_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		seq_kind_t kind;
		string     kw;
		int        pick;
		int        body_len;
		int        cut;
		int        next_drain;

		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		rx_byte <= 8'h00;
		result_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ignored extremes, highest live byte, a stray line feed
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(CH_LF);
		// Each keyword once, then a short capture with a carriage return in it,
		// ended by a line feed so the untouched store positions go out too
		send_text("RING");
		send_text("OK");
		send_text("+CLIP:");
		send_text(" \"5");
		push_byte(CH_CR);
		push_byte(CH_LF);
		drain();

		next_drain = bytes_sent + 400;
		while (bytes_sent < 1825) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) kind = SEQ_CLIP;
			else if (pick < 52) kind = SEQ_RING;
			else if (pick < 64) kind = SEQ_OK;
			else if (pick < 82) kind = SEQ_BROKEN;
			else kind = SEQ_NOISE;

			case (kind)
				SEQ_CLIP: begin
					send_text("+CLIP:");
					if ($urandom_range(0, 3) != 0)
						send_text(" \"");
					// Usually a number-sized body; sometimes short or far too long
					body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24)
						: $urandom_range(9, 13);
					for (int i = 0; i < body_len; i++) begin
						pick = $urandom_range(0, 99);
						if (pick < 70) push_byte(8'h30 + 8'($urandom_range(0, 9)));
						else if (pick < 78) push_byte(CH_CR);
						else if (pick < 88) push_byte(8'($urandom_range(1, 127)));
						else if (pick < 93) push_byte(8'($urandom_range(128, 255)));
						else if (pick < 96) push_byte(8'h00);
						else send_text("+CLIP:");
					end
					if ($urandom_range(0, 1) != 0)
						send_text("\",129");
					if ($urandom_range(0, 1) != 0)
						push_byte(CH_CR);
					// Leave a capture open now and then, so later traffic runs inside it
					if ($urandom_range(0, 9) != 0)
						push_byte(CH_LF);
				end
				SEQ_RING: send_text("\r\nRING\r\n");
				SEQ_OK: begin
					if ($urandom_range(0, 1) != 0)
						send_text("\r\n");
					send_text("OK\r\n");
				end
				SEQ_BROKEN: begin
					case ($urandom_range(0, 2))
						0:       kw = "RING";
						1:       kw = "+CLIP:";
						default: kw = "OK";
					endcase
					cut = $urandom_range(1, kw.len() - 1);
					send_text(kw.substr(0, cut - 1));
					push_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					repeat ($urandom_range(1, 8))
						push_byte(8'($urandom_range(0, 255)));
				end
			endcase

			// Let the pipe empty completely every few hundred words
			if (bytes_sent >= next_drain) begin
				drain();
				next_drain = bytes_sent + 400;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
